// File: rtl/hinted_bitmap_id_allocator_unit_defines.svh
// assertion macros for the hinted bitmap id allocator checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef HINTED_BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH
`define HINTED_BITMAP_ID_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define HBIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define HBIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset cycles
`define HBIA_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hbia_pkg.sv
// shared constants for the hinted bitmap id allocator
// no dependencies
package hbia_pkg;

  localparam int VALUE_W = 16;

  localparam int ID_COUNT_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [VALUE_W-1:0] TOP_TYPE_RESET = 16'hFFFF;

endpackage

// File: rtl/hinted_bitmap_id_allocator_unit.sv
// hinted bitmap id allocator, top level with the bitmap memory and sequencer
// depends on hbia_pkg
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+---------------------
// in      | in        | in_valid / in_stall  | hint
// out     | out       | out_valid / out_stall| granted_value, ok
// cfg     | in        | cfg_valid / cfg_ready| cfg_data (top_type)
//
// after rst the bitmap is cleared one word a cycle, every word once, with in_stall high
// a request whose hint is free steps through div, hint read, hint check and finish
// a request that scans adds a read and a check state for each of the k bitmap words read
// (one read port, one read then one priority encode per word)
// the result sits in an output register, so a stalled out beat does not block the
// next accept, only the finish of the following request
module hinted_bitmap_id_allocator_unit
  import hbia_pkg::*;
#(
  parameter int ID_COUNT  = ID_COUNT_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] hint,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] granted_value,
  output logic               ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VALUE_W-1:0] cfg_data
);

  // geometry of the bitmap
  localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int NW         = $clog2(WORD_COUNT + 1);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int LAST_BITS  = ID_COUNT - (WORD_COUNT - 1) * WORD_BITS;

  // index / WORD_BITS by reciprocal multiply, exact for 16-bit indexes
  localparam int SH     = VALUE_W + BW;
  localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W = 2 * VALUE_W + 1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_HREAD = 8'b0000_1000,
    ST_HCHK  = 8'b0001_0000,
    ST_SREAD = 8'b0010_0000,
    ST_SCHK  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // bitmap memory, one word per entry
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_en;
  logic [WW-1:0]        rd_addr;
  logic                 wr_en;
  logic [WW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // registers
  logic [VALUE_W-1:0] top_type;
  logic [VALUE_W-1:0] want_idx;
  logic               in_range;
  logic [PROD_W-1:0]  prod;
  logic [WW-1:0]      want_word;
  logic [BW-1:0]      want_bit;
  logic [NW-1:0]      nfh_word;
  logic [BW-1:0]      nfh_bit;
  logic [WW-1:0]      scan_word;
  logic [WW-1:0]      clr_cnt;
  logic [WW-1:0]      grant_word;
  logic [BW-1:0]      grant_bit;
  logic               grant_ok;

  // combinational helpers
  logic [VALUE_W:0]     diff;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem;
  logic [WORD_BITS-1:0] masked;
  logic                 scan_found;
  logic [BW-1:0]        scan_pos;
  logic                 first_word;
  logic                 last_word;
  logic                 out_free;
  logic                 hint_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // mirror hint to an index; negative when the hint is above top_type
  assign diff = {1'b0, top_type} - {1'b0, hint};

  // quotient and remainder of the registered product
  assign quot = VALUE_W'(prod >> SH);
  assign rem  = want_idx - VALUE_W'(32'(quot) * 32'(WORD_BITS));

  assign hint_hit   = in_range && !rd_data[want_bit];
  assign first_word = (NW'(scan_word) == nfh_word);
  assign last_word  = (scan_word == WW'(WORD_COUNT - 1));

  // mask bits below the scan start and bits past the last id, then find lowest zero
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      masked[j] = rd_data[j] | (first_word && (j < int'(nfh_bit)))
                             | (last_word && (j >= LAST_BITS));
    end
    scan_found = 1'b0;
    scan_pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!masked[j]) begin
        scan_found = 1'b1;
        scan_pos   = BW'(j);
      end
    end
  end

  // sequencer, memory port control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = scan_word;
    wr_en      = 1'b0;
    wr_addr    = scan_word;
    wr_data    = rd_data;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (clr_cnt == WW'(WORD_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        state_next = ST_HREAD;
      end
      ST_HREAD: begin
        rd_en      = 1'b1;
        rd_addr    = quot[WW-1:0];
        state_next = ST_HCHK;
      end
      ST_HCHK: begin
        if (hint_hit) begin
          wr_en      = 1'b1;
          wr_addr    = want_word;
          wr_data    = rd_data | (WORD_BITS'(1) << want_bit);
          state_next = ST_FIN;
        end else if (nfh_word == NW'(WORD_COUNT)) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SREAD;
        end
      end
      ST_SREAD: begin
        rd_en      = 1'b1;
        rd_addr    = scan_word;
        state_next = ST_SCHK;
      end
      ST_SCHK: begin
        if (scan_found) begin
          wr_en      = 1'b1;
          wr_addr    = scan_word;
          wr_data    = rd_data | (WORD_BITS'(1) << scan_pos);
          state_next = ST_FIN;
        end else if (last_word) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_SREAD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      top_type  <= TOP_TYPE_RESET;
      nfh_word  <= '0;
      nfh_bit   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        top_type <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + WW'(1);
      end
      // scan hit moves the start pointer past the granted bit
      if (state == ST_SCHK && scan_found) begin
        if (scan_pos == BW'(WORD_BITS - 1)) begin
          nfh_word <= NW'(scan_word) + NW'(1);
          nfh_bit  <= '0;
        end else begin
          nfh_word <= NW'(scan_word);
          nfh_bit  <= scan_pos + BW'(1);
        end
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        want_idx <= diff[VALUE_W-1:0];
        in_range <= !diff[VALUE_W] &&
                    ((VALUE_W + 1)'(diff[VALUE_W-1:0]) < (VALUE_W + 1)'(ID_COUNT));
      end
      ST_DIV: begin
        prod <= PROD_W'(want_idx) * PROD_W'(RECIP);
      end
      ST_HREAD: begin
        want_word <= quot[WW-1:0];
        want_bit  <= rem[BW-1:0];
      end
      ST_HCHK: begin
        grant_word <= want_word;
        grant_bit  <= want_bit;
        grant_ok   <= hint_hit;
        scan_word  <= nfh_word[WW-1:0];
      end
      ST_SCHK: begin
        grant_word <= scan_word;
        grant_bit  <= scan_pos;
        grant_ok   <= scan_found;
        if (!scan_found && !last_word) begin
          scan_word <= scan_word + WW'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ok <= grant_ok;
          if (grant_ok) begin
            // index mirrored back to a value, wraps when the index exceeds top_type
            granted_value <= top_type - VALUE_W'(32'(grant_word) * 32'(WORD_BITS)
                                                 + 32'(grant_bit));
          end else begin
            granted_value <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/hbia_checker.sv
// port-level checker for the hinted bitmap id allocator, bound to the top level
// depends on hbia_pkg and hinted_bitmap_id_allocator_unit_defines.svh
`include "hinted_bitmap_id_allocator_unit_defines.svh"

module hbia_checker
  import hbia_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] granted_value,
  input logic               ok
);

  // a stalled out beat holds
  `HBIA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted_value) && $stable(ok), "out beat changed while stalled")

  // reset starts the clearing pass and drops any pending result
  `HBIA_ASSERT_NXT_ALWAYS(a_rst_busy, rst, in_stall && !out_valid, "not busy or result left after reset")

  // one request at a time
  `HBIA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")

  // a failed allocation carries a zero value
  `HBIA_ASSERT_IMP(a_fail_zero, out_valid && !ok, granted_value == '0, "failure with nonzero value")

endmodule

bind hinted_bitmap_id_allocator_unit hbia_checker u_hbia_checker (.*);
